// ----- src/fhdc_pkg.sv -----
// Shared types and constants for the fan hysteresis duty controller.
package fhdc_pkg;

	typedef enum logic [1:0] {
		MODE_COLD     = 2'd0,
		MODE_NORMAL   = 2'd1,
		MODE_WARMING  = 2'd2,
		MODE_CRITICAL = 2'd3
	} fan_mode_t;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLD_ENTER     = 3'd0,
		REG_COLD_LEAVE     = 3'd1,
		REG_HOT_ENTER      = 3'd2,
		REG_HOT_LEAVE      = 3'd3,
		REG_CRITICAL_ENTER = 3'd4,
		REG_CRITICAL_LEAVE = 3'd5
	} cfg_reg_t;

	localparam int DUTY_W = 7;
	localparam logic [DUTY_W-1:0] DUTY_OFF  = 7'd0;
	localparam logic [DUTY_W-1:0] DUTY_BASE = 7'd20;
	localparam logic [DUTY_W-1:0] DUTY_SPAN = 7'd80;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

	// Duty span 80 = 64 + 16, so the scaled deviation needs this many extra bits.
	localparam int SCALE_BITS = 7;

	localparam int OUT_W = 16;

	localparam int RST_COLD_ENTER     = 20;
	localparam int RST_COLD_LEAVE     = 25;
	localparam int RST_HOT_ENTER      = 80;
	localparam int RST_HOT_LEAVE      = 75;
	localparam int RST_CRITICAL_ENTER = 120;
	localparam int RST_CRITICAL_LEAVE = 110;

endpackage

// ----- src/fan_hysteresis_duty_control_unit.sv -----
// Fan duty controller: hysteresis mode machine and bit-serial duty interpolation.
//
// Each temperature item updates the fan mode (cold, normal, warming, critical) at the
// input handshake, and one result item with the duty in percent and the new mode follows.
// Cold, normal and critical items, and warming items when critical_enter is not above
// hot_enter, go from the input handshake straight to ST_HOLD. Other warming items go
// through a restoring divider (ST_DIV) that produces one quotient bit per cycle over the
// TEMP_BITS+7 bits of the scaled deviation. In ST_HOLD the result moves into the output
// register with valid once that register is free, and the block returns to idle. One
// item is in work at a time; a new item is taken as soon as the previous result sits in
// the output register, even while that result still waits for the sink. The user must
// write thresholds through cfg_we/cfg_index/cfg_data only while the block is idle; the
// block itself does not enforce this. Indexes beyond critical_leave are ignored.
module fan_hysteresis_duty_control_unit
	import fhdc_pkg::*;
#(
	parameter int TEMP_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [CFG_IDX_W-1:0]                   cfg_index,
	input  logic [TEMP_BITS-1:0]                   cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((TEMP_BITS+7)/8)*8-1:0]         s_tdata,   // temperature
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [OUT_W-1:0]                       m_tdata    // duty_percent, fan_mode
);

	localparam int DW    = TEMP_BITS + SCALE_BITS;
	localparam int CNT_W = $clog2(DW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t                 state_q;
	fan_mode_t              mode_q;
	fan_mode_t              mode_next;
	logic [TEMP_BITS-1:0]   cold_enter_q, cold_leave_q, hot_enter_q, hot_leave_q;
	logic [TEMP_BITS-1:0]   critical_enter_q, critical_leave_q;
	logic [TEMP_BITS-1:0]   temperature;
	logic [TEMP_BITS-1:0]   dev;
	logic [DW-1:0]          dividend;
	logic [TEMP_BITS-1:0]   span_w;
	logic                   span_ok;
	logic [DW-1:0]          div_q;
	logic [TEMP_BITS-1:0]   rem_q;
	logic [TEMP_BITS-1:0]   span_q;
	logic [DUTY_W-1:0]      quo_q;
	logic                   ovf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TEMP_BITS:0]     trial;
	logic                   ge;
	logic [TEMP_BITS:0]     trial_sub;
	logic [DUTY_W-1:0]      quo_next;
	logic                   ovf_next;
	logic [DUTY_W-1:0]      duty_sat;
	logic [DUTY_W-1:0]      duty_q;
	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;
	logic                   in_acc;
	logic                   out_free;

	assign temperature = s_tdata[TEMP_BITS-1:0];
	assign s_tready    = (state_q == ST_IDLE);
	assign in_acc      = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign m_tvalid    = m_tvalid_q;
	assign m_tdata     = m_tdata_q;

	always_comb begin
		mode_next = mode_q;
		case (mode_q)
			MODE_COLD: begin
				if (temperature >= cold_leave_q) mode_next = MODE_NORMAL;
			end
			MODE_NORMAL: begin
				if (temperature < cold_enter_q)     mode_next = MODE_COLD;
				else if (temperature > hot_enter_q) mode_next = MODE_WARMING;
			end
			MODE_WARMING: begin
				if (temperature <= hot_leave_q)           mode_next = MODE_NORMAL;
				else if (temperature >= critical_enter_q) mode_next = MODE_CRITICAL;
			end
			MODE_CRITICAL: begin
				if (temperature <= critical_leave_q) mode_next = MODE_WARMING;
			end
			default: mode_next = MODE_NORMAL;
		endcase
	end

	// deviation clamped at zero, scaled by 80 as (dev << 6) + (dev << 4)
	assign dev      = (temperature > hot_enter_q) ? (temperature - hot_enter_q) : '0;
	assign dividend = DW'({dev, 6'b0}) + DW'({dev, 4'b0});
	assign span_w   = critical_enter_q - hot_enter_q;
	assign span_ok  = (critical_enter_q > hot_enter_q);

	// one restoring division step; remainder stays below the span
	assign trial     = {rem_q, div_q[DW-1]};
	assign ge        = (trial >= {1'b0, span_q});
	assign trial_sub = trial - {1'b0, span_q};
	assign quo_next  = {quo_q[DUTY_W-2:0], ge};
	assign ovf_next  = ovf_q | quo_q[DUTY_W-1];
	assign duty_sat  = (ovf_next || quo_next > DUTY_SPAN) ? DUTY_FULL : (DUTY_BASE + quo_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cold_enter_q     <= TEMP_BITS'(RST_COLD_ENTER);
			cold_leave_q     <= TEMP_BITS'(RST_COLD_LEAVE);
			hot_enter_q      <= TEMP_BITS'(RST_HOT_ENTER);
			hot_leave_q      <= TEMP_BITS'(RST_HOT_LEAVE);
			critical_enter_q <= TEMP_BITS'(RST_CRITICAL_ENTER);
			critical_leave_q <= TEMP_BITS'(RST_CRITICAL_LEAVE);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COLD_ENTER:     cold_enter_q     <= cfg_data;
				REG_COLD_LEAVE:     cold_leave_q     <= cfg_data;
				REG_HOT_ENTER:      hot_enter_q      <= cfg_data;
				REG_HOT_LEAVE:      hot_leave_q      <= cfg_data;
				REG_CRITICAL_ENTER: critical_enter_q <= cfg_data;
				REG_CRITICAL_LEAVE: critical_leave_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_NORMAL;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			cnt_q      <= '0;
			div_q      <= '0;
			rem_q      <= '0;
			span_q     <= '0;
			quo_q      <= '0;
			ovf_q      <= 1'b0;
			duty_q     <= '0;
		end else begin
			if (state_q == ST_HOLD && out_free) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)    m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						mode_q <= mode_next;
						div_q  <= dividend;
						span_q <= span_w;
						rem_q  <= '0;
						quo_q  <= '0;
						ovf_q  <= 1'b0;
						cnt_q  <= CNT_W'(DW - 1);
						case (mode_next)
							MODE_COLD:     duty_q <= DUTY_OFF;
							MODE_NORMAL:   duty_q <= DUTY_BASE;
							MODE_WARMING:  duty_q <= DUTY_FULL;
							MODE_CRITICAL: duty_q <= DUTY_FULL;
							default:       duty_q <= DUTY_FULL;
						endcase
						if (mode_next == MODE_WARMING && span_ok) state_q <= ST_DIV;
						else                                      state_q <= ST_HOLD;
					end
				end
				ST_DIV: begin
					div_q <= {div_q[DW-2:0], 1'b0};
					rem_q <= ge ? trial_sub[TEMP_BITS-1:0] : trial[TEMP_BITS-1:0];
					quo_q <= quo_next;
					ovf_q <= ovf_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						duty_q  <= duty_sat;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						m_tdata_q  <= OUT_W'({mode_q, duty_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DUTY_W-1:0] <= DUTY_FULL)
		else $error("duty above full scale");

	a_cold_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[DUTY_W+1:DUTY_W] == MODE_COLD |-> m_tdata[DUTY_W-1:0] == DUTY_OFF)
		else $error("cold mode with fan running");

	a_critical_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[DUTY_W+1:DUTY_W] == MODE_CRITICAL
		|-> m_tdata[DUTY_W-1:0] == DUTY_FULL)
		else $error("critical mode below full duty");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

endmodule
